>>> sv/cli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_pkg
// Shared types and constants of the circular list block: item layouts,
// operation and status codes, controller states and free map commands.
// ----------------------------------------------------------------------------
package cli_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int VALUE_W          = 32;
   localparam int LENGTH_W         = 5;

   typedef enum logic [1:0] {
      OP_INS_FRONT = 2'd0,
      OP_INS_END   = 2'd1,
      OP_DELETE    = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_LINK_TAIL,
      S_WALK
   } state_type;

   typedef struct packed {
      logic [1:0]                op;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [LENGTH_W-1:0] length;
   } rsp_type;

   // Commands from the controller to the free slot map.
   typedef struct packed {
      logic scan_clear;
      logic scan_next;
      logic take;
      logic release_slot;
   } free_cmd_type;

endpackage

>>> sv/cli_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module cli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/cli_free.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_free
// Free slot map. One bit per slot, set when the slot is free, and a scan
// pointer that steps through the map one slot per cycle while the scan_next
// command is given, to find the lowest free slot.
// ----------------------------------------------------------------------------
module cli_free #(
   parameter int CAPACITY = cli_pkg::DEFAULT_CAPACITY,
   localparam int SW      = $clog2(CAPACITY)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cli_pkg::free_cmd_type cmd,
   input  logic [SW-1:0]         rel_idx,
   output logic [SW-1:0]         scan_idx,
   output logic                  scan_hit
);
   import cli_pkg::*;

   logic [CAPACITY-1:0] free_ff;
   logic [CAPACITY-1:0] free_in;
   logic [SW-1:0]       scan_ff;
   logic [SW-1:0]       scan_in;

   always_comb begin
      free_in = free_ff;
      scan_in = scan_ff;
      if (cmd.scan_clear) begin
         scan_in = '0;
      end else if (cmd.scan_next) begin
         scan_in = scan_ff + SW'(1);
      end
      if (cmd.take) begin
         free_in[scan_ff] = 1'b0;
      end
      if (cmd.release_slot) begin
         free_in[rel_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '1;
         scan_ff <= '0;
      end else begin
         free_ff <= free_in;
         scan_ff <= scan_in;
      end
   end

   assign scan_idx = scan_ff;
   assign scan_hit = free_ff[scan_ff];

endmodule

>>> sv/circular_list_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_list_insert_delete
// Bounded circular singly linked list of signed values kept in a value RAM
// and a link RAM, with a free slot map and a tail pointer.
// ----------------------------------------------------------------------------
//  Channel   Ports                     Handshake
//  request   start, busy, req_item     taken when start is high and busy low
//  response  rsp_valid, rsp_item       one-cycle strobe, cannot be held off
//
//  An insert scans the free map one slot per cycle for the lowest free
//  slot, then links the new entry behind the tail (skipped at an empty list).
//  A delete walks from the head to a match or the last entry; the walk
//  reads one link per cycle from the link RAM. Full, empty and unused op
//  items end in the dispatch state. The registered response strobe comes in
//  the cycle after the last cycle of the item; busy is low in that cycle.
//  Reset marks every slot free and empties the list; the RAMs are not swept.
// ----------------------------------------------------------------------------
module circular_list_insert_delete #(
   parameter int CAPACITY = cli_pkg::DEFAULT_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cli_pkg::req_type req_item,
   output logic             rsp_valid,
   output cli_pkg::rsp_type rsp_item
);
   import cli_pkg::*;

   localparam int SW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [SW-1:0]       tail_ff, tail_in;
   logic [SW-1:0]       prev_ff, prev_in;
   logic [SW-1:0]       cur_ff, cur_in;
   logic [SW-1:0]       walk_ff, walk_in;
   logic [SW-1:0]       head_ff, head_in;
   logic [SW-1:0]       slot_ff, slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [SW-1:0]       rd_addr;
   logic                val_we;
   logic [SW-1:0]       val_wa;
   logic [VALUE_W-1:0]  val_rdata;
   logic                lnk_we;
   logic [SW-1:0]       lnk_wa;
   logic [SW-1:0]       lnk_wd;
   logic [SW-1:0]       lnk_rdata;

   free_cmd_type        free_cmd;
   logic [SW-1:0]       scan_idx;
   logic                scan_hit;

   logic                match;
   logic                last_entry;

   cli_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value_ram (
      .clock (clock),
      .we    (val_we),
      .waddr (val_wa),
      .wdata (value_ff),
      .raddr (rd_addr),
      .rdata (val_rdata)
   );

   cli_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link_ram (
      .clock (clock),
      .we    (lnk_we),
      .waddr (lnk_wa),
      .wdata (lnk_wd),
      .raddr (rd_addr),
      .rdata (lnk_rdata)
   );

   cli_free #(.CAPACITY(CAPACITY)) u_free (
      .clock    (clock),
      .reset    (reset),
      .cmd      (free_cmd),
      .rel_idx  (cur_ff),
      .scan_idx (scan_idx),
      .scan_hit (scan_hit)
   );

   assign match      = (val_rdata == value_ff);
   assign last_entry = ({{(CW-SW){1'b0}}, walk_ff} == (count_ff - CW'(1)));

   always_comb begin : next_state
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (op_ff)
               OP_INS_FRONT, OP_INS_END: begin
                  state_in = (count_ff >= CAP_C) ? S_IDLE : S_SCAN;
               end
               OP_DELETE: begin
                  state_in = (count_ff == '0) ? S_IDLE : S_WALK;
               end
               OP_NONE: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            if (scan_hit) begin
               state_in = (count_ff == '0) ? S_IDLE : S_LINK_TAIL;
            end
         end
         S_LINK_TAIL: begin
            state_in = S_IDLE;
         end
         S_WALK: begin
            if (match || last_entry) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin : datapath
      op_in        = op_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      tail_in      = tail_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      walk_in      = walk_ff;
      head_in      = head_ff;
      slot_in      = slot_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = tail_ff;
      val_we       = 1'b0;
      val_wa       = scan_idx;
      lnk_we       = 1'b0;
      lnk_wa       = scan_idx;
      lnk_wd       = head_ff;
      free_cmd     = '0;

      unique case (state_ff)
         S_IDLE: begin
            // The link of the tail is read every idle cycle, so it is ready
            // in the cycle after an item is taken.
            if (start) begin
               op_in    = op_type'(req_item.op);
               value_in = req_item.value;
            end
         end
         S_DISPATCH: begin
            rd_addr = lnk_rdata;
            unique case (op_ff)
               OP_INS_FRONT, OP_INS_END: begin
                  if (count_ff >= CAP_C) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: STAT_FULL, length: LENGTH_W'(count_ff)};
                  end else begin
                     head_in             = lnk_rdata;
                     free_cmd.scan_clear = 1'b1;
                  end
               end
               OP_DELETE: begin
                  if (count_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: STAT_EMPTY, length: LENGTH_W'(count_ff)};
                  end else begin
                     prev_in = tail_ff;
                     cur_in  = lnk_rdata;
                     walk_in = '0;
                  end
               end
               OP_NONE: begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STAT_OK, length: LENGTH_W'(count_ff)};
               end
            endcase
         end
         S_SCAN: begin
            if (scan_hit) begin
               free_cmd.take = 1'b1;
               val_we        = 1'b1;
               lnk_we        = 1'b1;
               slot_in       = scan_idx;
               if (count_ff == '0) begin
                  // A lone entry links to itself and is its own tail.
                  lnk_wd       = scan_idx;
                  tail_in      = scan_idx;
                  count_in     = count_ff + CW'(1);
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STAT_OK, length: LENGTH_W'(count_in)};
               end
            end else begin
               free_cmd.scan_next = 1'b1;
            end
         end
         S_LINK_TAIL: begin
            lnk_we = 1'b1;
            lnk_wa = tail_ff;
            lnk_wd = slot_ff;
            if (op_ff == OP_INS_END) begin
               tail_in = slot_ff;
            end
            count_in     = count_ff + CW'(1);
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: STAT_OK, length: LENGTH_W'(count_in)};
         end
         S_WALK: begin
            rd_addr = lnk_rdata;
            if (match) begin
               free_cmd.release_slot = 1'b1;
               count_in              = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  tail_in = '0;
               end else begin
                  lnk_we = 1'b1;
                  lnk_wa = prev_ff;
                  lnk_wd = lnk_rdata;
                  if (cur_ff == tail_ff) begin
                     tail_in = prev_ff;
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STAT_OK, length: LENGTH_W'(count_in)};
            end else if (last_entry) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STAT_NOT_FOUND, length: LENGTH_W'(count_ff)};
            end else begin
               prev_in = cur_ff;
               cur_in  = lnk_rdata;
               walk_in = walk_ff + SW'(1);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      value_ff <= value_in;
      prev_ff  <= prev_in;
      cur_ff   <= cur_in;
      walk_ff  <= walk_in;
      head_ff  <= head_in;
      slot_ff  <= slot_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("entry count above capacity");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_DISPATCH))
      else $error("accepted item did not reach dispatch");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) != S_IDLE))
      else $error("response without an item in progress");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> ({{(CW-SW){1'b0}}, walk_ff} < count_ff))
      else $error("delete walk ran past the list length");

   a_scan_finds_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (count_ff < CAP_C))
      else $error("free slot scan with a full list");
`endif

endmodule

>>> sim/circular_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_list_checker
// Watches the request and response channels of the circular list block,
// keeps its own copy of the list to work out each response, and compares
// every response field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module circular_list_checker
   import cli_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_valid,
   input  rsp_type rsp_item,
   output int      mismatches,
   output int      pending,
   output int      ok_hits,
   output int      miss_hits,
   output int      empty_hits,
   output int      full_hits
);

   localparam int SLOT_W = $clog2(CAPACITY);

   logic [VALUE_W-1:0] slot_val  [CAPACITY];
   logic [SLOT_W-1:0]  slot_next [CAPACITY];
   logic [CAPACITY-1:0] slot_free;
   logic [SLOT_W-1:0]  last_slot;
   int unsigned        entries;
   rsp_type            awaited_rsps[$];

   initial begin
      mismatches = 0;
      ok_hits    = 0;
      miss_hits  = 0;
      empty_hits = 0;
      full_hits  = 0;
   end

   assign pending = awaited_rsps.size();

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
   endtask

   function automatic status_type list_insert(input logic [VALUE_W-1:0] v, input bit at_end);
      int slot;
      slot = -1;
      if (entries >= CAPACITY) return STAT_FULL;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (slot_free[i]) slot = i;
      end
      if (slot < 0) return STAT_FULL;
      slot_free[slot] = 1'b0;
      slot_val[slot]  = v;
      if (entries == 0) begin
         slot_next[slot] = SLOT_W'(slot);
         last_slot       = SLOT_W'(slot);
      end else begin
         // The new entry goes right after the tail, so it is the new head
         // unless it also becomes the tail.
         slot_next[slot]      = slot_next[last_slot];
         slot_next[last_slot] = SLOT_W'(slot);
         if (at_end) last_slot = SLOT_W'(slot);
      end
      entries++;
      return STAT_OK;
   endfunction

   function automatic status_type list_delete(input logic [VALUE_W-1:0] v);
      logic [SLOT_W-1:0] prev;
      logic [SLOT_W-1:0] cur;
      if (entries == 0) return STAT_EMPTY;
      prev = last_slot;
      cur  = slot_next[prev];
      for (int i = 0; i < entries; i++) begin
         if (slot_val[cur] == v) begin
            if (entries == 1) begin
               last_slot = '0;
            end else begin
               slot_next[prev] = slot_next[cur];
               if (cur == last_slot) last_slot = prev;
            end
            slot_free[cur] = 1'b1;
            entries--;
            return STAT_OK;
         end
         prev = cur;
         cur  = slot_next[cur];
      end
      return STAT_NOT_FOUND;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type    want;
      status_type st;
      if (reset) begin
         slot_free = '1;
         last_slot = '0;
         entries   = 0;
         awaited_rsps.delete();
      end else begin
         // A response and a new item may share an edge; the response
         // belongs to an earlier item, so it is checked first.
         if (rsp_valid) begin
            if (awaited_rsps.size() == 0) begin
               report_mismatch($sformatf("response with none expected (status %0d length %0d)",
                                         rsp_item.status, rsp_item.length));
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_item.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_item.status, want.status));
               if (rsp_item.length !== want.length)
                  report_mismatch($sformatf("length %0d, expected %0d",
                                            rsp_item.length, want.length));
            end
         end
         if (start && !busy) begin
            case (op_type'(req_item.op))
               OP_INS_FRONT: st = list_insert(req_item.value, 1'b0);
               OP_INS_END:   st = list_insert(req_item.value, 1'b1);
               OP_DELETE:    st = list_delete(req_item.value);
               default:      st = STAT_OK;
            endcase
            case (st)
               STAT_OK:        ok_hits++;
               STAT_NOT_FOUND: miss_hits++;
               STAT_EMPTY:     empty_hits++;
               default:        full_hits++;
            endcase
            want.status = st;
            want.length = LENGTH_W'(entries);
            awaited_rsps.push_back(want);
         end
      end
   end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the circular list block with a short directed sequence and then
// with random fill and drain phases, with random gaps between items. The
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
   import cli_pkg::*;

   localparam int CAPACITY     = 16;
   localparam int RANDOM_ITEMS = 650;
   localparam int LIMIT_CYCLES = 500000;

   logic    clock;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   int mismatches;
   int pending;
   int ok_hits;
   int miss_hits;
   int empty_hits;
   int full_hits;

   int cycles     = 0;
   int inserts    = 0;
   int deletes    = 0;
   int idle_ops   = 0;
   bit no_idle    = 1'b0;
   bit fill_phase = 1'b1;

   // Values now in the list, as a multiset; used to aim deletes and to switch phases.
   logic [VALUE_W-1:0] live_vals[$];

   circular_list_insert_delete #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   circular_list_checker #(
      .CAPACITY(CAPACITY)
   ) i_checker (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .mismatches(mismatches),
      .pending   (pending),
      .ok_hits   (ok_hits),
      .miss_hits (miss_hits),
      .empty_hits(empty_hits),
      .full_hits (full_hits)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      if (no_idle || r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return $urandom;
      // A small pool gives duplicates and deletes that hit.
      if (r < 80) return VALUE_W'($signed($urandom_range(0, 7)) - 3);
      case ($urandom_range(0, 3))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // Starts at a rising edge and returns at the edge that takes the item.
   task automatic send_item(input op_type op, input logic [VALUE_W-1:0] v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= '{op: op, value: v};
      do @(posedge clock); while (busy);
      case (op)
         OP_INS_FRONT, OP_INS_END: begin
            inserts++;
            if (live_vals.size() < CAPACITY) live_vals.push_back(v);
         end
         OP_DELETE: begin
            deletes++;
            foreach (live_vals[i]) begin
               if (live_vals[i] == v) begin
                  live_vals.delete(i);
                  break;
               end
            end
         end
         default: idle_ops++;
      endcase
   endtask

   initial begin : stimulus
      op_type             op;
      logic [VALUE_W-1:0] v;
      int                 r;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty list, unused op, extremes, not found, tail,
      // head and last entry deletion, then a fill up to full.
      send_item(OP_DELETE, 32'd5);
      send_item(OP_NONE, 32'hFFFF_FFFF);
      send_item(OP_INS_FRONT, 32'h8000_0000);
      send_item(OP_INS_END, 32'h7FFF_FFFF);
      send_item(OP_INS_FRONT, 32'hFFFF_FFFF);
      send_item(OP_DELETE, 32'd12345);
      send_item(OP_DELETE, 32'h7FFF_FFFF);
      send_item(OP_DELETE, 32'hFFFF_FFFF);
      send_item(OP_DELETE, 32'h8000_0000);
      for (int i = 0; i < CAPACITY; i++)
         send_item(i[0] ? OP_INS_END : OP_INS_FRONT, (i % 5) * 32'h3333_3333);
      send_item(OP_INS_FRONT, 32'd1);
      send_item(OP_INS_END, 32'd2);

      // Random part: phases that fill the list and drain it again.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (fill_phase && live_vals.size() == CAPACITY && $urandom_range(0, 3) == 0)
            fill_phase = 1'b0;
         else if (!fill_phase && live_vals.size() == 0 && $urandom_range(0, 3) == 0)
            fill_phase = 1'b1;
         else if ($urandom_range(0, 49) == 0)
            fill_phase = !fill_phase;
         r = $urandom_range(0, 99);
         if (r < 3) begin
            op = OP_NONE;
            v  = $urandom;
         end else if (fill_phase ? r < 72 : r < 18) begin
            op = $urandom_range(0, 1) ? OP_INS_END : OP_INS_FRONT;
            v  = pick_value();
         end else begin
            op = OP_DELETE;
            if (live_vals.size() > 0 && $urandom_range(0, 99) < 80)
               v = live_vals[$urandom_range(0, live_vals.size() - 1)];
            else
               v = pick_value();
         end
         send_item(op, v);
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Sent %0d items: %0d inserts, %0d deletes, %0d unused ops.",
               inserts + deletes + idle_ops, inserts, deletes, idle_ops);
      $display("Responses: %0d ok, %0d not found, %0d empty, %0d full.",
               ok_hits, miss_hits, empty_hits, full_hits);
      if (mismatches == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
